// File: hdl/four_channel_dac_port_decoder_defines.svh
// assertion macros used by the checker file
`ifndef FOUR_CHANNEL_DAC_PORT_DECODER_DEFINES_SVH
`define FOUR_CHANNEL_DAC_PORT_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCDPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcdpd assertion failed");

// next-cycle implication, disabled during reset
`define FCDPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcdpd assertion failed");

`endif

// File: hdl/fcdpd_pkg.sv
package fcdpd_pkg;

  localparam int unsigned LVL_W     = 8;
  localparam int unsigned SUM_W     = 9;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned FAM_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 7;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 1;

  localparam logic [LVL_W-1:0] LVL_CENTER = 8'h80;
  localparam logic [FAM_W-1:0] FAM_RESET  = 7'h7f;

  localparam logic [CFG_IDX_W-1:0] CFG_DAC_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAM_EN = 1'd1;

  localparam logic [7:0] REG_B  = 8'h2c;
  localparam logic [7:0] REG_AD = 8'h2d;
  localparam logic [7:0] REG_C  = 8'h2e;

  localparam logic [7:0] RD_B     = 8'h80;
  localparam logic [7:0] RD_AD    = 8'h00;
  localparam logic [7:0] RD_C     = 8'h80;
  localparam logic [7:0] RD_OTHER = 8'hff;
  localparam logic [7:0] RD_NONE  = 8'h00;

  localparam logic [7:0] P_1F = 8'h1f;
  localparam logic [7:0] P_0F = 8'h0f;
  localparam logic [7:0] P_4F = 8'h4f;
  localparam logic [7:0] P_5F = 8'h5f;
  localparam logic [7:0] P_F1 = 8'hf1;
  localparam logic [7:0] P_F3 = 8'hf3;
  localparam logic [7:0] P_F9 = 8'hf9;
  localparam logic [7:0] P_FB = 8'hfb;
  localparam logic [7:0] P_3F = 8'h3f;
  localparam logic [7:0] P_B3 = 8'hb3;
  localparam logic [7:0] P_DF = 8'hdf;

  typedef enum logic [1:0] {
    CMD_PORT_WR = 2'd0,
    CMD_REG_WR  = 2'd1,
    CMD_REG_RD  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef logic [LVL_W-1:0] lvl_t;

  // channel write mask, bit0 is A
  function automatic logic [NUM_CH-1:0] port_mask(input logic [7:0] a,
                                                  input logic [FAM_W-1:0] f);
    logic to_ad;
    logic to_bc;
    logic [NUM_CH-1:0] m;
    to_ad = (a == P_FB && f[4] && !f[1]) || (a == P_DF && f[6]);
    to_bc = (a == P_B3) && f[5];
    m[0] = to_ad || (a == P_1F && f[0]) || (a == P_F1 && f[1]) || (a == P_3F && f[2]);
    m[1] = to_bc || (a == P_0F && (f[0] || f[3])) || (a == P_F3 && f[1]);
    m[2] = to_bc || (a == P_4F && (f[0] || f[3])) || (a == P_F9 && f[1]);
    m[3] = to_ad || (a == P_5F && (f[0] || f[2])) || (a == P_FB && f[1]);
    return m;
  endfunction

  function automatic logic [NUM_CH-1:0] reg_mask(input logic [7:0] a);
    logic [NUM_CH-1:0] m;
    m = '0;
    case (a)
      REG_B:   m = 4'b0010;
      REG_AD:  m = 4'b1001;
      REG_C:   m = 4'b0100;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] reg_read(input logic [7:0] a);
    logic [7:0] v;
    case (a)
      REG_B:   v = RD_B;
      REG_AD:  v = RD_AD;
      REG_C:   v = RD_C;
      default: v = RD_OTHER;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/four_channel_dac_port_decoder.sv
// Four-channel 8-bit DAC level keeper. Each transaction on the in_ stream is a port write,
// a register write (0x2C, 0x2D, 0x2E) or a register read, and produces exactly one result
// transaction carrying the selected channel level, the left (A+B) and right (C+D) sums,
// the register-hit flag and the read value. One transaction is taken every clock unless
// out_tready stalls the result register; each passes the input register, then the result
// register, and the input register can take one more while a result waits on out_tready.
// Channels reset to 0x80 with the DAC disabled. Writing 0 to dac_enable recenters all
// channels and blocks writes; configure only while no transaction is in flight.
module four_channel_dac_port_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [fcdpd_pkg::IN_DATA_W-1:0]       in_tdata,   // address, data, channel_select
  input  logic [fcdpd_pkg::IN_USER_W-1:0]       in_tuser,   // cmd
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [fcdpd_pkg::OUT_DATA_W-1:0]      out_tdata,  // selected_level, left_sum,
                                                            // right_sum, read_data
  output logic [fcdpd_pkg::OUT_USER_W-1:0]      out_tuser,  // reg_handled
  input  logic                                  cfg_we,
  input  logic [fcdpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcdpd_pkg::CFG_DAT_W-1:0]       cfg_data
);

  // input stage
  logic                  s1_valid_r;
  fcdpd_pkg::cmd_t       s1_cmd_r;
  logic [7:0]            s1_addr_r;
  logic [7:0]            s1_data_r;
  logic [1:0]            s1_sel_r;

  // state
  fcdpd_pkg::lvl_t       lvl_r [fcdpd_pkg::NUM_CH];
  fcdpd_pkg::lvl_t       lvl_nxt [fcdpd_pkg::NUM_CH];
  logic                  dac_en_r;
  logic [fcdpd_pkg::FAM_W-1:0] fam_r;

  // result stage
  logic                  out_valid_r;
  logic [fcdpd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                  out_hit_r;
  logic [fcdpd_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic                  out_hit_nxt;

  logic                  adv;
  logic [fcdpd_pkg::NUM_CH-1:0] wr_mask;
  logic [7:0]            rd_val;
  logic [fcdpd_pkg::SUM_W-1:0] left_sum;
  logic [fcdpd_pkg::SUM_W-1:0] right_sum;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;

  always_comb begin
    wr_mask = '0;
    rd_val  = fcdpd_pkg::RD_NONE;
    case (s1_cmd_r)
      fcdpd_pkg::CMD_PORT_WR: begin
        if (dac_en_r) begin
          wr_mask = fcdpd_pkg::port_mask(s1_addr_r, fam_r);
        end
      end
      fcdpd_pkg::CMD_REG_WR: begin
        if (dac_en_r) begin
          wr_mask = fcdpd_pkg::reg_mask(s1_addr_r);
        end
      end
      fcdpd_pkg::CMD_REG_RD: begin
        rd_val = fcdpd_pkg::reg_read(s1_addr_r);
      end
      default: begin
        wr_mask = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < fcdpd_pkg::NUM_CH; i++) begin
      lvl_nxt[i] = wr_mask[i] ? s1_data_r : lvl_r[i];
    end
    left_sum  = {1'b0, lvl_nxt[0]} + {1'b0, lvl_nxt[1]};
    right_sum = {1'b0, lvl_nxt[2]} + {1'b0, lvl_nxt[3]};
    out_data_nxt = {6'b0, rd_val, right_sum, left_sum, lvl_nxt[s1_sel_r]};
    out_hit_nxt  = (s1_addr_r == fcdpd_pkg::REG_B) || (s1_addr_r == fcdpd_pkg::REG_AD) ||
                   (s1_addr_r == fcdpd_pkg::REG_C);
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dac_en_r    <= 1'b0;
      fam_r       <= fcdpd_pkg::FAM_RESET;
      for (int i = 0; i < fcdpd_pkg::NUM_CH; i++) begin
        lvl_r[i] <= fcdpd_pkg::LVL_CENTER;
      end
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          for (int i = 0; i < fcdpd_pkg::NUM_CH; i++) begin
            lvl_r[i] <= lvl_nxt[i];
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          fcdpd_pkg::CFG_DAC_EN: begin
            dac_en_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              for (int i = 0; i < fcdpd_pkg::NUM_CH; i++) begin
                lvl_r[i] <= fcdpd_pkg::LVL_CENTER;
              end
            end
          end
          fcdpd_pkg::CFG_FAM_EN: begin
            fam_r <= cfg_data[fcdpd_pkg::FAM_W-1:0];
          end
          default: begin
            fam_r <= fam_r;
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= fcdpd_pkg::cmd_t'(in_tuser);
      s1_addr_r <= in_tdata[7:0];
      s1_data_r <= in_tdata[15:8];
      s1_sel_r  <= in_tdata[17:16];
    end
    if (adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
      out_hit_r  <= out_hit_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

endmodule

// File: hdl/fcdpd_checker.sv
`include "four_channel_dac_port_decoder_defines.svh"

module fcdpd_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [fcdpd_pkg::OUT_DATA_W-1:0]      out_tdata,
  input logic [fcdpd_pkg::OUT_USER_W-1:0]      out_tuser
);

  // stalled result holds
  `FCDPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // sums of two 8-bit levels never reach 0x1ff
  `FCDPD_ASSERT_NOW(a_sum_range, clk, rst_n, out_tvalid, (out_tdata[16:8] != 9'h1ff) && (out_tdata[25:17] != 9'h1ff))

  // a register hit reads back 0x80 or 0x00
  `FCDPD_ASSERT_NOW(a_rd_hit, clk, rst_n, out_tvalid && out_tuser[0], (out_tdata[33:26] == fcdpd_pkg::RD_B) || (out_tdata[33:26] == fcdpd_pkg::RD_AD))

  // no hit reads back 0xff or nothing
  `FCDPD_ASSERT_NOW(a_rd_miss, clk, rst_n, out_tvalid && !out_tuser[0], (out_tdata[33:26] == fcdpd_pkg::RD_OTHER) || (out_tdata[33:26] == fcdpd_pkg::RD_NONE))

  // with the result side idle, input is never back-pressured
  `FCDPD_ASSERT_NOW(a_in_ready, clk, rst_n, !out_tvalid && in_tvalid, in_tready)

endmodule

bind four_channel_dac_port_decoder fcdpd_checker u_fcdpd_checker (.*);

// File: dv/four_channel_dac_port_decoder_tb.sv
`timescale 1ns / 100ps

module four_channel_dac_port_decoder_tb;

  typedef struct packed {
    fcdpd_pkg::lvl_t             level;
    logic [fcdpd_pkg::SUM_W-1:0] left;
    logic [fcdpd_pkg::SUM_W-1:0] right;
    logic                        hit;
    logic [7:0]                  rd;
  } dac_result_t;

  typedef struct packed {
    logic                            is_cfg;
    logic [fcdpd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [fcdpd_pkg::CFG_DAT_W-1:0] cfg_val;
    fcdpd_pkg::cmd_t                 cmd;
    logic [7:0]                      addr;
    logic [7:0]                      data;
    logic [1:0]                      sel;
    logic                            has_golden;
    dac_result_t                     golden;
  } dir_row_t;

  localparam logic [10:0][7:0] PORT_ADDRS = {fcdpd_pkg::P_1F, fcdpd_pkg::P_0F,
                                             fcdpd_pkg::P_4F, fcdpd_pkg::P_5F,
                                             fcdpd_pkg::P_F1, fcdpd_pkg::P_F3,
                                             fcdpd_pkg::P_F9, fcdpd_pkg::P_FB,
                                             fcdpd_pkg::P_3F, fcdpd_pkg::P_B3,
                                             fcdpd_pkg::P_DF};
  localparam logic [2:0][7:0]  REG_ADDRS  = {fcdpd_pkg::REG_B, fcdpd_pkg::REG_AD,
                                             fcdpd_pkg::REG_C};
  localparam int unsigned      WDOG_LIMIT = 2000;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [fcdpd_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [fcdpd_pkg::IN_USER_W-1:0]  in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [fcdpd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [fcdpd_pkg::OUT_USER_W-1:0] out_tuser;
  logic                             cfg_we     = 1'b0;
  logic [fcdpd_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [fcdpd_pkg::CFG_DAT_W-1:0]  cfg_data   = '0;

  // predictor state
  fcdpd_pkg::lvl_t             chan_lvl [fcdpd_pkg::NUM_CH];
  logic                        dac_on;
  logic [fcdpd_pkg::FAM_W-1:0] fam_on;

  dac_result_t level_q [$];
  dir_row_t    dir_tbl [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle     = 1'b0;

  four_channel_dac_port_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // address, data, channel_select
    .in_tuser   (in_tuser),   // cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // selected_level, left_sum, right_sum, read_data
    .out_tuser  (out_tuser),  // reg_handled
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void levels_center();
    for (int i = 0; i < fcdpd_pkg::NUM_CH; i++) chan_lvl[i] = fcdpd_pkg::LVL_CENTER;
  endfunction

  function automatic dac_result_t dac_result(fcdpd_pkg::lvl_t level,
                                             logic [fcdpd_pkg::SUM_W-1:0] left,
                                             logic [fcdpd_pkg::SUM_W-1:0] right, logic hit,
                                             logic [7:0] rd);
    dac_result_t r;
    r.level = level;
    r.left  = left;
    r.right = right;
    r.hit   = hit;
    r.rd    = rd;
    return r;
  endfunction

  // applies one transaction to the channel levels and returns the result it yields
  function automatic dac_result_t dac_predict(fcdpd_pkg::cmd_t cmd, logic [7:0] addr,
                                              logic [7:0] data, logic [1:0] sel);
    logic [fcdpd_pkg::NUM_CH-1:0] wr;
    dac_result_t                  r;
    wr = '0;
    if (dac_on && cmd == fcdpd_pkg::CMD_PORT_WR) begin
      case (addr)
        fcdpd_pkg::P_1F: wr[0] = fam_on[0];
        fcdpd_pkg::P_0F: wr[1] = fam_on[0] | fam_on[3];
        fcdpd_pkg::P_4F: wr[2] = fam_on[0] | fam_on[3];
        fcdpd_pkg::P_5F: wr[3] = fam_on[0] | fam_on[2];
        fcdpd_pkg::P_F1: wr[0] = fam_on[1];
        fcdpd_pkg::P_F3: wr[1] = fam_on[1];
        fcdpd_pkg::P_F9: wr[2] = fam_on[1];
        fcdpd_pkg::P_FB: begin
          wr[0] = fam_on[4] & ~fam_on[1];
          wr[3] = fam_on[1] | fam_on[4];
        end
        fcdpd_pkg::P_3F: wr[0] = fam_on[2];
        fcdpd_pkg::P_B3: begin
          wr[1] = fam_on[5];
          wr[2] = fam_on[5];
        end
        fcdpd_pkg::P_DF: begin
          wr[0] = fam_on[6];
          wr[3] = fam_on[6];
        end
        default: ;
      endcase
    end else if (dac_on && cmd == fcdpd_pkg::CMD_REG_WR) begin
      case (addr)
        fcdpd_pkg::REG_B:  wr[1] = 1'b1;
        fcdpd_pkg::REG_AD: begin
          wr[0] = 1'b1;
          wr[3] = 1'b1;
        end
        fcdpd_pkg::REG_C:  wr[2] = 1'b1;
        default: ;
      endcase
    end
    for (int i = 0; i < fcdpd_pkg::NUM_CH; i++) if (wr[i]) chan_lvl[i] = data;
    r.level = chan_lvl[sel];
    r.left  = {1'b0, chan_lvl[0]} + {1'b0, chan_lvl[1]};
    r.right = {1'b0, chan_lvl[2]} + {1'b0, chan_lvl[3]};
    r.hit   = (addr == fcdpd_pkg::REG_B) || (addr == fcdpd_pkg::REG_AD) ||
              (addr == fcdpd_pkg::REG_C);
    r.rd    = fcdpd_pkg::RD_NONE;
    if (cmd == fcdpd_pkg::CMD_REG_RD) begin
      case (addr)
        fcdpd_pkg::REG_B:  r.rd = fcdpd_pkg::RD_B;
        fcdpd_pkg::REG_AD: r.rd = fcdpd_pkg::RD_AD;
        fcdpd_pkg::REG_C:  r.rd = fcdpd_pkg::RD_C;
        default:           r.rd = fcdpd_pkg::RD_OTHER;
      endcase
    end
    return r;
  endfunction

  function automatic void add_txn(fcdpd_pkg::cmd_t cmd, logic [7:0] addr, logic [7:0] data,
                                  logic [1:0] sel, logic has_golden, dac_result_t golden);
    dir_row_t row;
    row            = '0;
    row.cmd        = cmd;
    row.addr       = addr;
    row.data       = data;
    row.sel        = sel;
    row.has_golden = has_golden;
    row.golden     = golden;
    dir_tbl.push_back(row);
  endfunction

  function automatic void add_cfg(logic [fcdpd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [fcdpd_pkg::CFG_DAT_W-1:0] val);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    dir_tbl.push_back(row);
  endfunction

  task automatic send_txn(fcdpd_pkg::cmd_t cmd, logic [7:0] addr, logic [7:0] data,
                          logic [1:0] sel, logic has_golden, dac_result_t golden);
    int unsigned gap;
    dac_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, sel, data, addr};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    r = dac_predict(cmd, addr, data, sel);
    level_q.push_back(has_golden ? golden : r);
  endtask

  // wait until every expected result is back and the pipeline has emptied
  task automatic drain();
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // caller lowers cfg_we after the last write of a group
  task automatic cfg_write(logic [fcdpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [fcdpd_pkg::CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == fcdpd_pkg::CFG_DAC_EN) begin
      dac_on = val[0];
      if (!val[0]) levels_center();
    end else begin
      fam_on = val[fcdpd_pkg::FAM_W-1:0];
    end
  endtask

  initial begin
    dir_row_t                        row;
    int unsigned                     pick;
    fcdpd_pkg::cmd_t                 cmd;
    logic [7:0]                      addr;
    logic [fcdpd_pkg::CFG_DAT_W-1:0] fam_v;
    levels_center();
    dac_on = 1'b0;
    fam_on = fcdpd_pkg::FAM_RESET;

    // disabled after reset: writes ignored, reads return fixed values
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_1F,   8'h12, 2'd0, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b0, fcdpd_pkg::RD_NONE));
    add_txn(fcdpd_pkg::CMD_REG_WR,  fcdpd_pkg::REG_AD, 8'h55, 2'd3, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b1, fcdpd_pkg::RD_NONE));
    add_txn(fcdpd_pkg::CMD_REG_RD,  fcdpd_pkg::REG_B,  8'hff, 2'd1, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b1, fcdpd_pkg::RD_B));
    add_txn(fcdpd_pkg::CMD_REG_RD,  fcdpd_pkg::REG_AD, 8'h00, 2'd2, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b1, fcdpd_pkg::RD_AD));
    add_txn(fcdpd_pkg::CMD_REG_RD,  fcdpd_pkg::REG_C,  8'h5a, 2'd3, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b1, fcdpd_pkg::RD_C));
    add_txn(fcdpd_pkg::CMD_REG_RD,  8'hff,             8'h00, 2'd0, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b0, fcdpd_pkg::RD_OTHER));
    add_cfg(fcdpd_pkg::CFG_DAC_EN, 7'd1);
    // every port except 0x3F with every family enabled
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_1F,   8'hff, 2'd0, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_0F,   8'h00, 2'd1, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_4F,   8'haa, 2'd2, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_5F,   8'h55, 2'd3, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_F1,   8'h01, 2'd0, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_F3,   8'hfe, 2'd1, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_F9,   8'h80, 2'd2, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_FB,   8'h7f, 2'd3, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_B3,   8'hc3, 2'd1, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_DF,   8'h3c, 2'd0, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, 8'h00,             8'hee, 2'd2, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_NOP,     fcdpd_pkg::REG_AD, 8'h11, 2'd0, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_REG_WR,  fcdpd_pkg::REG_B,  8'h01, 2'd1, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_REG_WR,  fcdpd_pkg::REG_AD, 8'hfe, 2'd3, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_REG_WR,  fcdpd_pkg::REG_C,  8'h7f, 2'd2, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_REG_WR,  8'h30,             8'h99, 2'd0, 1'b0, '0);
    // shared port routed to A and D when its own family is off
    add_cfg(fcdpd_pkg::CFG_FAM_EN, 7'h10);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_FB,   8'h33, 2'd0, 1'b0, '0);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_1F,   8'h44, 2'd0, 1'b0, '0);
    add_cfg(fcdpd_pkg::CFG_FAM_EN, 7'h00);
    add_txn(fcdpd_pkg::CMD_PORT_WR, fcdpd_pkg::P_DF,   8'h77, 2'd3, 1'b0, '0);
    // disable recenters, re-enable keeps the centered levels
    add_cfg(fcdpd_pkg::CFG_DAC_EN, 7'd0);
    add_txn(fcdpd_pkg::CMD_REG_RD,  fcdpd_pkg::REG_AD, 8'h21, 2'd2, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b1, fcdpd_pkg::RD_AD));
    add_cfg(fcdpd_pkg::CFG_DAC_EN, 7'd1);
    add_txn(fcdpd_pkg::CMD_NOP,     8'hff,             8'hff, 2'd3, 1'b1,
            dac_result(fcdpd_pkg::LVL_CENTER, 9'h100, 9'h100, 1'b0, fcdpd_pkg::RD_NONE));
    add_cfg(fcdpd_pkg::CFG_FAM_EN, 7'h7f);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.is_cfg) begin
        drain();
        cfg_write(row.cfg_idx, row.cfg_val);
        cfg_we <= 1'b0;
      end else begin
        send_txn(row.cmd, row.addr, row.data, row.sel, row.has_golden, row.golden);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 0) fam_v = 7'h7f;
      else if (ph == 1) fam_v = 7'h00;
      else if (ph == 2) fam_v = (7'($urandom_range(0, 127)) & 7'h7d) | 7'h10;
      else fam_v = 7'($urandom_range(0, 127));
      cfg_write(fcdpd_pkg::CFG_DAC_EN, (ph == 3) ? 7'd0 : 7'd1);
      cfg_write(fcdpd_pkg::CFG_FAM_EN, fam_v);
      cfg_we  <= 1'b0;
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < 85; n++) begin
        pick = $urandom_range(0, 99);
        cmd  = (pick < 50) ? fcdpd_pkg::CMD_PORT_WR : (pick < 75) ? fcdpd_pkg::CMD_REG_WR :
               (pick < 90) ? fcdpd_pkg::CMD_REG_RD : fcdpd_pkg::CMD_NOP;
        addr = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0) begin
          if (cmd == fcdpd_pkg::CMD_PORT_WR) addr = PORT_ADDRS[4'($urandom_range(0, 10))];
          else addr = REG_ADDRS[2'($urandom_range(0, 2))];
        end
        send_txn(cmd, addr, 8'($urandom()), 2'($urandom_range(0, 3)), 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    dac_result_t want;
    dac_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.level = out_tdata[7:0];
      got.left  = out_tdata[16:8];
      got.right = out_tdata[25:17];
      got.rd    = out_tdata[33:26];
      got.hit   = out_tuser[0];
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: tdata %h", out_tdata);
      end else begin
        want = level_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp lvl %h l %h r %h hit %b rd %h,",
                      " got lvl %h l %h r %h hit %b rd %h"},
                     want.level, want.left, want.right, want.hit, want.rd,
                     got.level, got.left, got.right, got.hit, got.rd);
        end
      end
    end
  end

  // no transaction on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
